/* hw/rtl/fwsr_pkg.sv */
// Package for the FIFO with second-entry removal and swap.
// Holds the request and response payload types and the operation codes.
// No dependencies.
package fwsr_pkg;

   localparam int WORD_WIDTH = 32;
   localparam int CSR_WIDTH  = 5;

   localparam logic [1:0] KIND_ENQUEUE       = 2'd0;
   localparam logic [1:0] KIND_DEQUEUE       = 2'd1;
   localparam logic [1:0] KIND_REMOVE_SECOND = 2'd2;
   localparam logic [1:0] KIND_SWAP          = 2'd3;

   typedef logic signed [WORD_WIDTH-1:0] word_type;

   typedef struct packed {
      logic [1:0] kind;
      word_type   data_in;
   } req_type;

   typedef struct packed {
      logic     ok;
      word_type data_out;
      logic     is_empty;
      logic     is_full;
   } rsp_type;

endpackage

/* hw/rtl/fwsr_mem.sv */
// Ring store of the queue: one write port, two registered read ports.
// Read data appears in the cycle after the read enable. Uses fwsr_pkg.
module fwsr_mem #(
   parameter int DEPTH = 16,
   parameter int PW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [PW-1:0]       wr_addr,
   input  fwsr_pkg::word_type  wr_data,
   input  logic                rd_en,
   input  logic [PW-1:0]       rd_addr_a,
   input  logic [PW-1:0]       rd_addr_b,
   output fwsr_pkg::word_type  rd_data_a,
   output fwsr_pkg::word_type  rd_data_b
);

   fwsr_pkg::word_type mem [DEPTH];
   fwsr_pkg::word_type rd_a_ff;
   fwsr_pkg::word_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* hw/rtl/fwsr_ctrl.sv */
// Sequencer of the queue: head pointer, entry count, operation decode and
// the read-modify-write steps on the ring store. Uses fwsr_pkg.
module fwsr_ctrl #(
   parameter int DEPTH = 16,
   parameter int PW    = 4,
   parameter int CW    = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  fwsr_pkg::req_type   req_data,
   output logic                rsp_valid,
   output fwsr_pkg::rsp_type   rsp_data,
   input  logic [CW-1:0]       cap,
   output logic                wr_en,
   output logic [PW-1:0]       wr_addr,
   output fwsr_pkg::word_type  wr_data,
   output logic                rd_en,
   output logic [PW-1:0]       rd_addr_a,
   output logic [PW-1:0]       rd_addr_b,
   input  fwsr_pkg::word_type  rd_data_a,
   input  fwsr_pkg::word_type  rd_data_b
);

   localparam int SW = CW + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWAP2
   } state_type;

   state_type         state_ff;
   logic [PW-1:0]     head_ff;
   logic [CW-1:0]     count_ff;
   logic [1:0]        kind_ff;
   logic              rsp_valid_ff;
   fwsr_pkg::rsp_type rsp_ff;

   logic              accept;
   logic              req_ok;
   logic [PW-1:0]     second;
   logic [SW-1:0]     tail_sum;
   logic [PW-1:0]     tail;
   logic [CW-1:0]     count_dec;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   assign second   = (head_ff == PW'(DEPTH - 1)) ? '0 : head_ff + PW'(1);
   assign tail_sum = SW'(head_ff) + SW'(count_ff);
   assign tail     = (tail_sum >= SW'(DEPTH)) ? PW'(tail_sum - SW'(DEPTH))
                                              : PW'(tail_sum);
   assign count_dec = count_ff - CW'(1);

   always_comb begin
      unique case (req_data.kind)
         fwsr_pkg::KIND_ENQUEUE:       req_ok = (count_ff < cap);
         fwsr_pkg::KIND_REMOVE_SECOND: req_ok = (count_ff >= CW'(2));
         default:                      req_ok = (count_ff != '0);
      endcase
   end

   assign rd_en     = accept;
   assign rd_addr_a = head_ff;
   assign rd_addr_b = second;

   // store write mux: enqueue at transfer, then the rewrite steps
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = tail;
      wr_data = req_data.data_in;
      unique case (state_ff)
         ST_IDLE: begin
            wr_en = accept && req_ok && (req_data.kind == fwsr_pkg::KIND_ENQUEUE);
         end
         ST_EXEC: begin
            if (kind_ff == fwsr_pkg::KIND_REMOVE_SECOND) begin
               wr_en   = 1'b1;
               wr_addr = second;
               wr_data = rd_data_a;
            end else if (kind_ff == fwsr_pkg::KIND_SWAP && count_ff >= CW'(2)) begin
               wr_en   = 1'b1;
               wr_addr = head_ff;
               wr_data = rd_data_b;
            end
         end
         ST_SWAP2: begin
            wr_en   = 1'b1;
            wr_addr = second;
            wr_data = rd_data_a;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  kind_ff <= req_data.kind;
                  if (!req_ok) begin
                     rsp_valid_ff     <= 1'b1;
                     rsp_ff.ok        <= 1'b0;
                     rsp_ff.data_out  <= '0;
                     rsp_ff.is_empty  <= (count_ff == '0);
                     rsp_ff.is_full   <= (count_ff >= cap);
                  end else if (req_data.kind == fwsr_pkg::KIND_ENQUEUE) begin
                     count_ff         <= count_ff + CW'(1);
                     rsp_valid_ff     <= 1'b1;
                     rsp_ff.ok        <= 1'b1;
                     rsp_ff.data_out  <= '0;
                     rsp_ff.is_empty  <= 1'b0;
                     rsp_ff.is_full   <= ((count_ff + CW'(1)) >= cap);
                  end else begin
                     state_ff <= ST_EXEC;
                  end
               end
            end
            ST_EXEC: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff.ok    <= 1'b1;
               unique case (kind_ff)
                  fwsr_pkg::KIND_SWAP: begin
                     rsp_ff.data_out <= rd_data_a;
                     rsp_ff.is_empty <= 1'b0;
                     rsp_ff.is_full  <= (count_ff >= cap);
                     state_ff        <= (count_ff >= CW'(2)) ? ST_SWAP2 : ST_IDLE;
                  end
                  default: begin
                     // dequeue returns the head, remove-second the entry behind it
                     rsp_ff.data_out <= (kind_ff == fwsr_pkg::KIND_DEQUEUE) ? rd_data_a
                                                                          : rd_data_b;
                     rsp_ff.is_empty <= (count_dec == '0);
                     rsp_ff.is_full  <= (count_dec >= cap);
                     head_ff         <= second;
                     count_ff        <= count_dec;
                     state_ff        <= ST_IDLE;
                  end
               endcase
            end
            ST_SWAP2: begin
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* hw/rtl/fifo_with_second_removal_and_swap.sv */
// Bounded FIFO of signed 32-bit words with dequeue, remove-second and swap.
// Top level: capacity register and clamp; instantiates fwsr_ctrl and fwsr_mem.
//
// One command is taken per transfer (start high while busy low) and gives
// exactly one result, shown on rsp_data for a single cycle with rsp_valid
// high. The receiver cannot stall: the result must be taken in that cycle.
// An enqueue or any refused command reports in the cycle after the transfer
// and never raises busy. Dequeue and remove-second raise busy while the
// store's registered read comes back; a swap with two or more entries stays
// busy for a second write, since the store has a single write port and the
// exchange takes two writes. The capacity value is clamped to 1..DEPTH; the
// register must be written only while idle (not enforced by the block).
module fifo_with_second_removal_and_swap #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  fwsr_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output fwsr_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [fwsr_pkg::CSR_WIDTH-1:0]      csr_wdata
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [fwsr_pkg::CSR_WIDTH-1:0] capacity_ff;
   logic [CW-1:0]                  cap;

   logic               wr_en;
   logic [PW-1:0]      wr_addr;
   fwsr_pkg::word_type wr_data;
   logic               rd_en;
   logic [PW-1:0]      rd_addr_a;
   logic [PW-1:0]      rd_addr_b;
   fwsr_pkg::word_type rd_data_a;
   fwsr_pkg::word_type rd_data_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= fwsr_pkg::CSR_WIDTH'(16);
      end else if (csr_we) begin
         capacity_ff <= csr_wdata;
      end
   end

   // zero acts as one, anything above DEPTH as DEPTH
   always_comb begin
      if (capacity_ff == '0) begin
         cap = CW'(1);
      end else if (32'(capacity_ff) > 32'(DEPTH)) begin
         cap = CW'(DEPTH);
      end else begin
         cap = CW'(capacity_ff);
      end
   end

   fwsr_ctrl #(
      .DEPTH (DEPTH),
      .PW    (PW),
      .CW    (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cap       (cap),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   fwsr_mem #(
      .DEPTH (DEPTH),
      .PW    (PW)
   ) u_mem (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

endmodule
